FILE: sv/osa_edit_distance_defines.svh
// Assertion macros shared by the osa_edit_distance RTL.
// Depends on nothing; users supply clk_i and rst_ni in scope.
`ifndef OSA_EDIT_DISTANCE_DEFINES_SVH
`define OSA_EDIT_DISTANCE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define OSA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define OSA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/osa_pkg.sv
// Shared types and constants for the osa_edit_distance block.
// No dependencies.
`default_nettype none

package osa_pkg;

  localparam int OSA_MAX_LEN    = 32;
  localparam int OSA_CHAR_WIDTH = 16;

  localparam int KIND_W     = 2;
  localparam int CH_FIELD_W = 16;
  localparam int DIST_W     = 6;

  localparam logic [KIND_W-1:0] KIND_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

  localparam logic [DIST_W-1:0] DIST_SAT = 6'd63;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CH_FIELD_W-1:0] ch;
  } osa_in_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } osa_out_t;

  // Token handed from one cell to the next along the row.
  typedef struct packed {
    logic go;   // cell fired in the previous cycle
    logic eq;   // its first-word char matched the current second-word char
  } osa_ctl_t;

  typedef enum logic {
    ST_IDLE,
    ST_SWEEP
  } osa_state_e;

endpackage

`default_nettype wire

FILE: sv/osa_cell.sv
// One cell of the systolic row: holds one first-word char and two table entries.
// Depends on osa_pkg.
`default_nettype none

module osa_cell
  import osa_pkg::*;
#(
  parameter int IDX = 1,
  parameter int DW  = 6,
  parameter int CW  = OSA_CHAR_WIDTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          clr_i,
  input  wire logic          en_i,
  input  wire logic          wr_i,
  input  wire logic [CW-1:0] wr_ch_i,
  input  wire logic [CW-1:0] b_i,
  input  wire logic [CW-1:0] prevb_i,
  input  wire logic          jgt1_i,
  input  wire osa_ctl_t      left_ctl_i,
  input  wire logic [DW-1:0] left_prev_i,
  input  wire logic [DW-1:0] left_diag_i,
  input  wire logic [DW-1:0] left_op2_i,
  input  wire logic [DW-1:0] left_relay_i,
  output osa_ctl_t           ctl_o,
  output logic [DW-1:0]      prev_o,
  output logic [DW-1:0]      diag_o,
  output logic [DW-1:0]      op2_o,
  output logic [DW-1:0]      relay_o
);

  localparam logic [DW-1:0] IdxVal = DW'(IDX);

  logic [CW-1:0] ch_q;
  logic [DW-1:0] prev_q, prev2_q, op2_q, relay_q;
  osa_ctl_t      ctl_q, ctl_d;
  logic          fire;
  logic [DW:0]   sub_c, del_c, ins_c, tr_c, m1, m2, v;
  logic          tr_ok;

  assign fire = left_ctl_i.go & en_i;

  always_comb begin
    sub_c = {1'b0, left_diag_i} + ((ch_q == b_i) ? (DW+1)'(0) : (DW+1)'(1));
    del_c = {1'b0, prev_q} + (DW+1)'(1);
    ins_c = {1'b0, left_prev_i} + (DW+1)'(1);
    tr_c  = {1'b0, left_relay_i} + (DW+1)'(1);
    tr_ok = jgt1_i & left_ctl_i.eq & (ch_q == prevb_i);
    m1    = (del_c < ins_c) ? del_c : ins_c;
    m2    = (sub_c < m1) ? sub_c : m1;
    v     = (tr_ok && (tr_c < m2)) ? tr_c : m2;
    ctl_d.go = fire;
    ctl_d.eq = (ch_q == b_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= IdxVal;
      prev2_q <= IdxVal;
      ctl_q   <= '0;
    end else if (clr_i) begin
      prev_q  <= IdxVal;
      prev2_q <= IdxVal;
      ctl_q   <= '0;
    end else begin
      ctl_q <= ctl_d;
      if (fire) begin
        prev2_q <= prev_q;
        prev_q  <= v[DW-1:0];  // distance never exceeds MAX_LEN
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      ch_q <= wr_ch_i;
    end
    if (fire) begin
      op2_q   <= prev2_q;
      relay_q <= left_op2_i;
    end
  end

  assign ctl_o   = ctl_q;
  assign prev_o  = prev_q;
  assign diag_o  = prev2_q;
  assign op2_o   = op2_q;
  assign relay_o = relay_q;

endmodule

`default_nettype wire

FILE: sv/osa_edit_distance.sv
// Optimal string alignment (restricted Damerau-Levenshtein) distance engine.
// First-word chars load one per cycle, while no sweep runs, into a row of MAX_LEN
// cells. Each second-word char launches a token that walks the row one cell per
// cycle, and the block takes no new request until the walk is done. First-word
// chars, overflowed chars and end requests start no walk. An end request emits
// {distance, overflow} through an output register and clears the block, and is
// held off while a walk runs or while a previous result waits.
// Depends on osa_pkg and osa_edit_distance_defines.svh.
`default_nettype none

`include "osa_edit_distance_defines.svh"

module osa_edit_distance
  import osa_pkg::*;
#(
  parameter int MAX_LEN    = OSA_MAX_LEN,
  parameter int CHAR_WIDTH = OSA_CHAR_WIDTH
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire osa_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output osa_out_t     out_data_o
);

  localparam int DW   = $clog2(MAX_LEN + 1);
  localparam int ChIn = (CHAR_WIDTH < CH_FIELD_W) ? CHAR_WIDTH : CH_FIELD_W;
  localparam logic [DW-1:0] MaxLenVal = DW'(MAX_LEN);

  osa_state_e state_q, state_d;
  logic [DW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] first_len_q, second_len_q;
  logic [CHAR_WIDTH-1:0] prev_ch_q, b_q, prevb_q, ch_c;
  logic ovf_q, go_q, out_valid_q;
  osa_out_t out_data_q;

  logic acc, is_first, is_second, is_end, launch, clr;
  logic [DW+5:0] dext;
  logic [DW-1:0] dsel;

  osa_ctl_t      ctl   [0:MAX_LEN];
  logic [DW-1:0] prev  [0:MAX_LEN];
  logic [DW-1:0] diag  [0:MAX_LEN];
  logic [DW-1:0] op2   [0:MAX_LEN];
  logic [DW-1:0] relay [0:MAX_LEN];

  assign ch_c = CHAR_WIDTH'(in_data_i.ch[ChIn-1:0]);

  assign in_ready_o = (state_q == ST_IDLE) &&
                      ((in_data_i.kind != KIND_END) || !out_valid_q || out_ready_i);
  assign acc = in_valid_i & in_ready_o;

  always_comb begin
    is_first  = 1'b0;
    is_second = 1'b0;
    is_end    = 1'b0;
    unique case (in_data_i.kind)
      KIND_FIRST:  is_first  = 1'b1;
      KIND_SECOND: is_second = 1'b1;
      KIND_END:    is_end    = 1'b1;
      default:     ;
    endcase
  end

  assign launch = acc & is_second & (second_len_q < MaxLenVal);
  assign clr    = acc & is_end;

  // Column 0 of the table acts as the left neighbor of cell 1.
  assign ctl[0]   = '{go: go_q, eq: 1'b0};
  assign prev[0]  = second_len_q;
  assign diag[0]  = second_len_q - DW'(1);
  assign op2[0]   = second_len_q - DW'(2);
  assign relay[0] = '0;

  for (genvar k = 1; k <= MAX_LEN; k++) begin : g_cell
    osa_cell #(
      .IDX (k),
      .DW  (DW),
      .CW  (CHAR_WIDTH)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .clr_i        (clr),
      .en_i         (first_len_q >= DW'(k)),
      .wr_i         (acc && is_first && (second_len_q == '0) &&
                     (first_len_q == DW'(k - 1))),
      .wr_ch_i      (ch_c),
      .b_i          (b_q),
      .prevb_i      (prevb_q),
      .jgt1_i       (second_len_q > DW'(1)),
      .left_ctl_i   (ctl[k-1]),
      .left_prev_i  (prev[k-1]),
      .left_diag_i  (diag[k-1]),
      .left_op2_i   (op2[k-1]),
      .left_relay_i (relay[k-1]),
      .ctl_o        (ctl[k]),
      .prev_o       (prev[k]),
      .diag_o       (diag[k]),
      .op2_o        (op2[k]),
      .relay_o      (relay[k])
    );
  end

  assign dsel = prev[first_len_q];
  assign dext = (DW+6)'(dsel);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (launch && (first_len_q != '0)) begin
          state_d = ST_SWEEP;
          cnt_d   = first_len_q;
        end
      end
      ST_SWEEP: begin
        cnt_d = cnt_q - DW'(1);
        if (cnt_q == DW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_len_q  <= '0;
      second_len_q <= '0;
      prev_ch_q    <= '0;
      ovf_q        <= 1'b0;
      go_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      go_q <= launch;
      if (clr) begin
        first_len_q  <= '0;
        second_len_q <= '0;
        prev_ch_q    <= '0;
        ovf_q        <= 1'b0;
        out_valid_q  <= 1'b1;
      end else begin
        if (out_ready_i) begin
          out_valid_q <= 1'b0;
        end
        if (acc && is_first && (second_len_q == '0)) begin
          if (first_len_q == MaxLenVal) begin
            ovf_q <= 1'b1;
          end else begin
            first_len_q <= first_len_q + DW'(1);
          end
        end
        if (acc && is_second) begin
          if (launch) begin
            second_len_q <= second_len_q + DW'(1);
            prev_ch_q    <= ch_c;
          end else begin
            ovf_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (launch) begin
      b_q     <= ch_c;
      prevb_q <= prev_ch_q;
    end
    if (clr) begin
      out_data_q.distance <= (dext > (DW+6)'(DIST_SAT)) ? DIST_SAT : dext[DIST_W-1:0];
      out_data_q.overflow <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `OSA_ASSERT_NOW(a_sweep_blocks, state_q == ST_SWEEP, !in_ready_o,
    "request accepted during a column sweep")
  `OSA_ASSERT_NOW(a_cnt_range, state_q == ST_SWEEP,
    (cnt_q != '0) && (cnt_q <= first_len_q), "sweep counter out of range")
  `OSA_ASSERT_NEXT(a_end_clears, clr,
    out_valid_o && (first_len_q == '0) && (second_len_q == '0) && !ovf_q,
    "end request did not emit a result and clear the lengths")
  `OSA_ASSERT_NEXT(a_first_locked, acc && is_first && (second_len_q != '0),
    $stable(first_len_q), "first word grew after the second word started")

endmodule

`default_nettype wire

FILE: bench/osa_distance_checker.sv
// Request/result checker for osa_edit_distance: tracks both words and the
// DP columns, predicts the distance of each pair and compares results.
// Depends on osa_pkg.
module osa_distance_checker
  import osa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    in_ready_i,
  input  osa_in_t in_data_i,
  input  logic    out_valid_i,
  input  logic    out_ready_i,
  input  osa_out_t out_data_i,
  output int      fail_count_o,
  output int      pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [OSA_CHAR_WIDTH-1:0] word_a [OSA_MAX_LEN];
  int                        len_a;
  int                        len_b;
  int                        col_last   [OSA_MAX_LEN+1];
  int                        col_before [OSA_MAX_LEN+1];
  logic [OSA_CHAR_WIDTH-1:0] last_b;
  logic                      ovf_seen;

  osa_out_t distance_q[$];
  osa_out_t want;
  int       fails = 0;

  task automatic report_mismatch(string msg);
    fails++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  task automatic clear_words();
    for (int i = 0; i <= OSA_MAX_LEN; i++) begin
      col_last[i]   = i;
      col_before[i] = i;
    end
    len_a    = 0;
    len_b    = 0;
    last_b   = '0;
    ovf_seen = 1'b0;
  endtask

  function automatic int min2(int x, int y);
    return (x < y) ? x : y;
  endfunction

  // One new DP column for second-word char b.
  task automatic add_column(logic [OSA_CHAR_WIDTH-1:0] b);
    int fresh [OSA_MAX_LEN+1];
    int j;
    int v;
    int cost;
    j = len_b + 1;
    fresh[0] = j;
    for (int i = 1; i <= OSA_MAX_LEN; i++) begin
      if (i <= len_a) begin
        cost = (word_a[i-1] == b) ? 0 : 1;
        v = min2(col_last[i-1] + cost, min2(col_last[i] + 1, fresh[i-1] + 1));
        // adjacent transposition
        if (i > 1 && j > 1 && word_a[i-1] == last_b && word_a[i-2] == b)
          v = min2(v, col_before[i-2] + 1);
        fresh[i] = v;
      end else begin
        fresh[i] = col_last[i] + 1;
      end
    end
    col_before = col_last;
    col_last   = fresh;
    last_b     = b;
    len_b      = j;
  endtask

  task automatic apply_request(osa_in_t req);
    int d;
    case (req.kind)
      KIND_FIRST: begin
        // first-word chars after the second word started are dropped silently
        if (len_b == 0) begin
          if (len_a >= OSA_MAX_LEN) begin
            ovf_seen = 1'b1;
          end else begin
            word_a[len_a] = req.ch[OSA_CHAR_WIDTH-1:0];
            len_a++;
          end
        end
      end
      KIND_SECOND: begin
        if (len_b >= OSA_MAX_LEN) begin
          ovf_seen = 1'b1;
        end else begin
          add_column(req.ch[OSA_CHAR_WIDTH-1:0]);
        end
      end
      KIND_END: begin
        d = col_last[len_a];
        if (d > DIST_SAT) d = DIST_SAT;
        distance_q.insert(distance_q.size(),
                          osa_out_t'{distance: DIST_W'(d), overflow: ovf_seen});
        clear_words();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_words();
      distance_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (distance_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d with no request pending",
                                    out_data_i.distance, out_data_i.overflow));
        end else begin
          want = distance_q.pop_front();
          if (out_data_i.distance !== want.distance)
            report_mismatch($sformatf("distance got %0d expected %0d",
                                      out_data_i.distance, want.distance));
          if (out_data_i.overflow !== want.overflow)
            report_mismatch($sformatf("overflow got %0b expected %0b",
                                      out_data_i.overflow, want.overflow));
        end
      end
      if (in_valid_i && in_ready_i) apply_request(in_data_i);
    end
    pending_o    <= distance_q.size();
    fail_count_o <= fails;
  end

endmodule

FILE: bench/tb_osa_edit_distance.sv
// Top of the osa_edit_distance bench: clock, reset, request stimulus and
// result back-pressure; checking lives in osa_distance_checker.
// Depends on osa_pkg, osa_edit_distance and osa_distance_checker.
module tb_osa_edit_distance
  import osa_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam int ITEMS     = 1950;
  localparam int LIMIT     = 400000;
  localparam int DRAIN     = 100;
  localparam int HOLD_AT   = 2000;
  localparam int HOLD_LEN  = 600;
  localparam int CALM_LO   = 6000;
  localparam int CALM_HI   = 9000;
  localparam int IDLE_PCT  = 35;

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_ready;
  osa_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  osa_out_t out_data;

  int fail_count;
  int pending;
  int cycle = 0;
  int counted = 0;
  logic calm;

  always #5 clk_i = ~clk_i;

  assign calm = (cycle >= CALM_LO) && (cycle < CALM_HI);

  osa_edit_distance dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  osa_distance_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle >= LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    int hold;
    out_ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (cycle == HOLD_AT) begin
        out_ready <= 1'b0;
        hold = 0;
        while (hold < HOLD_LEN) begin
          @(posedge clk_i);
          hold++;
        end
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Drive one request; valid stays up until accepted.
  task automatic send_raw(logic [KIND_W-1:0] kind, logic [CH_FIELD_W-1:0] ch);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= osa_in_t'{kind: kind, ch: ch};
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_req(logic [KIND_W-1:0] kind, logic [CH_FIELD_W-1:0] ch);
    send_raw(kind, ch);
    counted++;
  endtask

  function automatic logic [CH_FIELD_W-1:0] pick_char(bit full, logic [CH_FIELD_W-1:0] base,
                                                      int span);
    if (full) return CH_FIELD_W'($urandom);
    return base + CH_FIELD_W'($urandom_range(span - 1));
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 6) return $urandom_range(OSA_MAX_LEN + 1, OSA_MAX_LEN + 4);
    if (r < 12) return 0;
    return $urandom_range(1, 7);
  endfunction

  // One word pair, usually the second derived from the first by a few edits,
  // with a little noise mixed in.
  task automatic send_pair();
    logic [CH_FIELD_W-1:0] a[$];
    logic [CH_FIELD_W-1:0] b[$];
    logic [CH_FIELD_W-1:0] tmp;
    logic [CH_FIELD_W-1:0] base;
    bit full;
    int span;
    int la;
    int lb;
    int p;
    full = ($urandom_range(3) == 0);
    base = CH_FIELD_W'($urandom);
    span = $urandom_range(1, 4);
    la   = pick_len();
    for (int i = 0; i < la; i++) a.insert(a.size(), pick_char(full, base, span));
    if ($urandom_range(4) == 0) begin
      lb = pick_len();
      for (int i = 0; i < lb; i++) b.insert(b.size(), pick_char(full, base, span));
    end else begin
      b = a;
      repeat ($urandom_range(0, 3)) begin
        case ($urandom_range(3))
          0: if (b.size() >= 2) begin
            p = $urandom_range(b.size() - 2);
            tmp = b[p];
            b[p] = b[p+1];
            b[p+1] = tmp;
          end
          1: if (b.size() > 0) b[$urandom_range(b.size() - 1)] = pick_char(full, base, span);
          2: b.insert($urandom_range(b.size()), pick_char(full, base, span));
          default: if (b.size() > 0) b.delete($urandom_range(b.size() - 1));
        endcase
      end
    end
    foreach (a[i]) begin
      if ($urandom_range(99) < 4) send_raw(KIND_UNUSED, CH_FIELD_W'($urandom));
      send_req(KIND_FIRST, a[i]);
    end
    foreach (b[i]) begin
      if (i > 0 && $urandom_range(99) < 4) send_raw(KIND_FIRST, CH_FIELD_W'($urandom));
      send_req(KIND_SECOND, b[i]);
    end
    send_req(KIND_END, CH_FIELD_W'($urandom));
  endtask

  initial begin
    rst_ni   = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both words empty, then an unused kind that must be dropped
    send_req(KIND_END, 16'hFFFF);
    send_raw(KIND_UNUSED, 16'hFFFF);
    // adjacent swap: "ab" vs "ba"
    send_req(KIND_FIRST, 16'h0061);
    send_req(KIND_FIRST, 16'h0062);
    send_req(KIND_SECOND, 16'h0062);
    send_req(KIND_SECOND, 16'h0061);
    send_req(KIND_END, 16'h0000);
    // late first-word char is ignored
    send_req(KIND_FIRST, 16'h1234);
    send_req(KIND_SECOND, 16'h1234);
    send_raw(KIND_FIRST, 16'h5678);
    send_req(KIND_END, 16'h5555);
    // extreme char codes
    send_req(KIND_FIRST, 16'h0000);
    send_req(KIND_SECOND, 16'hFFFF);
    send_req(KIND_END, 16'hAAAA);
    // empty first word
    send_req(KIND_SECOND, 16'h8001);
    send_req(KIND_SECOND, 16'h7FFE);
    send_req(KIND_END, 16'h0000);
    // empty second word
    send_req(KIND_FIRST, 16'hFFFF);
    send_req(KIND_FIRST, 16'h8000);
    send_req(KIND_FIRST, 16'h0001);
    send_req(KIND_END, 16'hFFFF);

    while (counted < ITEMS) send_pair();

    in_valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/osa_pkg.sv
sv/osa_cell.sv
sv/osa_edit_distance.sv
bench/osa_distance_checker.sv
bench/tb_osa_edit_distance.sv
